@@ hdl/stid_pkg.sv @@
// Shared types and codes for the sorted table insert/delete unit.
package stid_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 8;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOAD   = 2'd3
  } cell_op_t;

  typedef struct packed {
    func_t                      func;
    logic signed [VALUE_W-1:0]  value;
    logic        [INDEX_W-1:0]  index;
  } request_t;

  typedef struct packed {
    status_t                    status;
    logic        [COUNT_W-1:0]  removed_count;
    logic        [COUNT_W-1:0]  table_size;
    logic signed [VALUE_W-1:0]  read_value;
  } result_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  value;
    logic        [INDEX_W-1:0]  index;
  } cell_ctrl_t;

endpackage

@@ hdl/stid_cell.sv @@
// One table slot: holds an entry, compares it and trades it with its neighbors.
module stid_cell #(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 8
) (
  input  logic                        clk,
  input  stid_pkg::cell_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]            fill,
  input  logic signed [31:0]          entry_below,
  input  logic                        gt_below,
  input  logic signed [31:0]          entry_above,
  input  logic signed [31:0]          tap_above,
  output logic signed [31:0]          entry,
  output logic                        gt,
  output logic                        match,
  output logic signed [31:0]          tap
);
  import stid_pkg::*;

  localparam bit SEL_OK = CELL_INDEX < (1 << INDEX_W);

  logic valid;
  logic ge;
  logic sel;

  assign valid = CNT_W'(CELL_INDEX) < fill;
  assign gt    = !valid || (entry > ctrl.value);
  assign ge    = !valid || (entry >= ctrl.value);
  assign match = valid && (entry == ctrl.value);
  assign sel   = SEL_OK && (ctrl.index == INDEX_W'(CELL_INDEX));

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_INSERT: begin
        if (gt) begin
          entry <= gt_below ? entry_below : ctrl.value;
        end
      end
      OP_REMOVE: begin
        if (ge) begin
          entry <= entry_above;
        end
      end
      OP_HOLD, OP_LOAD: begin
      end
      default: begin
      end
    endcase
    tap <= (ctrl.op == OP_LOAD && sel) ? entry : tap_above;
  end

endmodule

@@ hdl/sorted_table_insert_delete_unit.sv @@
// Sorted table unit: a chain of compare-and-shift cells with a sequencing controller.
// Insert, unused codes and out-of-range reads: result strobe in the cycle after start; 1 item/cycle.
// Delete: one equal entry leaves the chain per cycle; result once no equal entry is left.
// Read: the entry walks down the tap chain one cell per cycle; result once it reaches cell 0.
// The result strobe lasts one cycle and cannot be stalled; busy is low whenever start is taken.
// Synchronous reset empties the table and idles the controller; entry contents are not cleared.
module sorted_table_insert_delete_unit #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  stid_pkg::request_t  request,
  output logic                busy,
  output logic                done,
  output stid_pkg::result_t   result
);
  import stid_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DELETE = 3'b010,
    S_READ   = 3'b100
  } state_t;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          fill, fill_next;
  logic [CNT_W-1:0]          count, count_next;
  logic signed [VALUE_W-1:0] del_value, del_value_next;
  logic [INDEX_W-1:0]        rd_cnt, rd_cnt_next;
  logic                      done_next;
  result_t                   result_next;
  cell_ctrl_t                ctrl;

  logic signed [31:0] entry_v [TABLE_DEPTH];
  logic signed [31:0] tap_v   [TABLE_DEPTH];
  logic signed [31:0] below_v [TABLE_DEPTH];
  logic signed [31:0] above_v [TABLE_DEPTH];
  logic signed [31:0] tap_up_v[TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt_v;
  logic [TABLE_DEPTH-1:0] gt_below_v;
  logic [TABLE_DEPTH-1:0] match_v;
  logic                   any_match;

  assign busy      = (state != S_IDLE);
  assign any_match = |match_v;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign below_v[i]    = '0;
      assign gt_below_v[i] = 1'b0;
    end else begin : g_mid
      assign below_v[i]    = entry_v[i-1];
      assign gt_below_v[i] = gt_v[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign above_v[i]  = entry_v[i];
      assign tap_up_v[i] = '0;
    end else begin : g_low
      assign above_v[i]  = entry_v[i+1];
      assign tap_up_v[i] = tap_v[i+1];
    end

    stid_cell #(
      .CELL_INDEX (i),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .fill        (fill),
      .entry_below (below_v[i]),
      .gt_below    (gt_below_v[i]),
      .entry_above (above_v[i]),
      .tap_above   (tap_up_v[i]),
      .entry       (entry_v[i]),
      .gt          (gt_v[i]),
      .match       (match_v[i]),
      .tap         (tap_v[i])
    );
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    count_next     = count;
    del_value_next = del_value;
    rd_cnt_next    = rd_cnt;
    done_next      = 1'b0;
    result_next    = result;
    ctrl.op        = OP_HOLD;
    ctrl.value     = request.value;
    ctrl.index     = request.index;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          result_next.status        = ST_OK;
          result_next.removed_count = '0;
          result_next.table_size    = COUNT_W'(fill);
          result_next.read_value    = '0;
          unique case (request.func)
            FUNC_INSERT: begin
              done_next = 1'b1;
              if (fill == CNT_W'(TABLE_DEPTH)) begin
                result_next.status = ST_FULL;
              end else begin
                ctrl.op                = OP_INSERT;
                fill_next              = fill + 1'b1;
                result_next.table_size = COUNT_W'(fill + 1'b1);
              end
            end
            FUNC_DELETE: begin
              del_value_next = request.value;
              count_next     = '0;
              state_next     = S_DELETE;
            end
            FUNC_READ: begin
              if (CMP_W'(request.index) < CMP_W'(fill)) begin
                ctrl.op     = OP_LOAD;
                rd_cnt_next = request.index;
                state_next  = S_READ;
              end else begin
                done_next          = 1'b1;
                result_next.status = ST_BAD_INDEX;
              end
            end
            FUNC_NONE: begin
              done_next = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_DELETE: begin
        ctrl.value = del_value;
        if (any_match) begin
          ctrl.op    = OP_REMOVE;
          fill_next  = fill - 1'b1;
          count_next = count + 1'b1;
        end else begin
          done_next                 = 1'b1;
          state_next                = S_IDLE;
          result_next.status        = (count == '0) ? ST_NOT_FOUND : ST_OK;
          result_next.removed_count = COUNT_W'(count);
          result_next.table_size    = COUNT_W'(fill);
          result_next.read_value    = '0;
        end
      end
      S_READ: begin
        if (rd_cnt == '0) begin
          done_next                 = 1'b1;
          state_next                = S_IDLE;
          result_next.status        = ST_OK;
          result_next.removed_count = '0;
          result_next.table_size    = COUNT_W'(fill);
          result_next.read_value    = tap_v[0];
        end else begin
          rd_cnt_next = rd_cnt - 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
    count     <= count_next;
    del_value <= del_value_next;
    rd_cnt    <= rd_cnt_next;
    result    <= result_next;
  end

endmodule

@@ tb/sv/stid_checker.sv @@
// Checker for the sorted table unit: tracks the table, predicts each result and compares.
`timescale 1ns / 100ps
module stid_checker
  import stid_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  request_t  request,
  input  logic      done,
  input  result_t   result,
  output int        fail_count,
  output int        outstanding,
  output int        checked
);

  logic signed [VALUE_W-1:0] shadow_entries [TABLE_DEPTH];
  int                        shadow_fill;
  result_t                   expected_results [$];

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic result_t apply_to_table(input request_t req);
    result_t                   res;
    logic signed [VALUE_W-1:0] v;
    int                        pos;
    int                        keep;
    int                        k;
    res        = '0;
    res.status = ST_OK;
    v          = req.value;
    case (req.func)
      FUNC_INSERT: begin
        if (shadow_fill >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_fill && shadow_entries[pos] <= v) pos++;
          for (k = shadow_fill; k > pos; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[pos] = v;
          shadow_fill++;
        end
      end
      FUNC_DELETE: begin
        keep = 0;
        for (k = 0; k < shadow_fill; k++) begin
          if (shadow_entries[k] != v) begin
            shadow_entries[keep] = shadow_entries[k];
            keep++;
          end
        end
        res.removed_count = COUNT_W'(shadow_fill - keep);
        if (keep == shadow_fill) res.status = ST_NOT_FOUND;
        shadow_fill = keep;
      end
      FUNC_READ: begin
        if (int'(req.index) < shadow_fill) begin
          res.read_value = shadow_entries[req.index];
        end else begin
          res.status = ST_BAD_INDEX;
        end
      end
      default: ;
    endcase
    res.table_size = COUNT_W'(shadow_fill);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    result_t exp_res;
    if (rst) begin
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          exp_res = expected_results.pop_front();
          checked++;
          if (result.status !== exp_res.status)
            report_mismatch($sformatf("status: expected %s, got %0d",
                            exp_res.status.name(), result.status));
          if (result.removed_count !== exp_res.removed_count)
            report_mismatch($sformatf("removed_count: expected %0d, got %0d",
                            exp_res.removed_count, result.removed_count));
          if (result.table_size !== exp_res.table_size)
            report_mismatch($sformatf("table_size: expected %0d, got %0d",
                            exp_res.table_size, result.table_size));
          if (result.read_value !== exp_res.read_value)
            report_mismatch($sformatf("read_value: expected %0d, got %0d",
                            exp_res.read_value, result.read_value));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_to_table(request));
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the sorted table unit: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import stid_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int REQ_W       = $bits(request_t);

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  int fail_count;
  int outstanding;
  int checked;

  int idle_pct = 0;
  int n_insert = 0;
  int n_delete = 0;
  int n_read   = 0;
  int n_none   = 0;

  logic signed [VALUE_W-1:0] value_pool [16];
  int                        pool_size = 1;

  always #5 clk = ~clk;

  sorted_table_insert_delete_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  stid_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .checked    (checked)
  );

  task automatic issue_request(input func_t f, input logic signed [VALUE_W-1:0] v,
                               input logic [INDEX_W-1:0] idx);
    request_t req;
    req.func  = f;
    req.value = v;
    req.index = idx;
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (f)
      FUNC_INSERT: n_insert++;
      FUNC_DELETE: n_delete++;
      FUNC_READ:   n_read++;
      default:     n_none++;
    endcase
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      request <= request_t'(REQ_W'({$urandom, $urandom}));
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic refill_pool(input int size);
    pool_size = size;
    for (int i = 0; i < size; i++) begin
      case ($urandom_range(5))
        0:       value_pool[i] = 32'sh8000_0000;
        1:       value_pool[i] = 32'sh7fff_ffff;
        2:       value_pool[i] = 32'sh0;
        3:       value_pool[i] = -32'sd1;
        4:       value_pool[i] = 32'($urandom_range(20)) - 32'd10;
        default: value_pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 75) return value_pool[$urandom_range(pool_size - 1)];
    return $urandom;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(1) == 0) return INDEX_W'($urandom_range(127));
    return INDEX_W'($urandom_range(15));
  endfunction

  task automatic run_segment(input int n, input int pct_ins, input int pct_del,
                             input int pct_read);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < pct_ins)
        issue_request(FUNC_INSERT, pick_value(), INDEX_W'($urandom));
      else if (roll < pct_ins + pct_del)
        issue_request(FUNC_DELETE, pick_value(), INDEX_W'($urandom));
      else if (roll < pct_ins + pct_del + pct_read)
        issue_request(FUNC_READ, $urandom, pick_index());
      else
        issue_request(FUNC_NONE, $urandom, INDEX_W'($urandom));
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    issue_request(FUNC_READ,   32'sh0, 7'd0);
    issue_request(FUNC_DELETE, 32'sh0, 7'd0);
    issue_request(FUNC_NONE,   32'sh0, 7'd0);
    issue_request(FUNC_INSERT, 32'sh7fff_ffff, 7'd0);
    issue_request(FUNC_INSERT, 32'sh8000_0000, 7'd127);
    issue_request(FUNC_INSERT, 32'sh0, 7'd0);
    issue_request(FUNC_INSERT, -32'sd1, 7'd0);
    issue_request(FUNC_INSERT, 32'sh0, 7'd0);
    issue_request(FUNC_INSERT, 32'sh1, 7'd0);
    issue_request(FUNC_READ,   32'sh0, 7'd0);
    issue_request(FUNC_READ,   32'sh0, 7'd5);
    issue_request(FUNC_READ,   32'sh0, 7'd6);
    issue_request(FUNC_READ,   32'shffff_ffff, 7'd127);
    issue_request(FUNC_DELETE, 32'sh0, 7'd0);
    issue_request(FUNC_DELETE, 32'sd12345, 7'd0);
    issue_request(FUNC_NONE,   32'shffff_ffff, 7'd127);
    issue_request(FUNC_READ,   32'sh0, 7'd3);
    issue_request(FUNC_DELETE, 32'sh8000_0000, 7'd0);
    issue_request(FUNC_DELETE, 32'sh7fff_ffff, 7'd0);
    issue_request(FUNC_READ,   32'sh0, 7'd0);
    issue_request(FUNC_READ,   32'sh0, 7'd1);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       idle_pct = 0;
        1:       idle_pct = 80;
        default: idle_pct = 15;
      endcase
      refill_pool(16);
      run_segment(180, 90, 0, 8);
      refill_pool($urandom_range(2, 8));
      run_segment(100, 20, 55, 20);
      wait_drained();
      refill_pool(1);
      run_segment(140, 95, 0, 5);
      issue_request(FUNC_DELETE, value_pool[0], 7'd0);
      refill_pool(2);
      run_segment(60, 40, 30, 25);
      wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Run covered %0d requests: %0d insert, %0d delete, %0d read, %0d unused code.",
             n_insert + n_delete + n_read + n_none, n_insert, n_delete, n_read, n_none);
    $display("Table filled past capacity and drained under no, heavy and light sender gaps;"
             , " %0d results compared.", checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d results outstanding", outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
